[hw/rtl/knn_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knn_pkg
// shared types and constants of the nearest-neighbor classifier
// ----------------------------------------------------------------------------
package knn_pkg;

  localparam int MAX_ROWS     = 1024;
  localparam int MAX_FEATURES = 64;
  localparam int MAX_K        = 16;
  localparam int NUM_CLASSES  = 16;

  localparam int ROW_W   = $clog2(MAX_ROWS);
  localparam int CNT_W   = $clog2(MAX_ROWS + 1);
  localparam int FEAT_W  = $clog2(MAX_FEATURES);
  localparam int ADDR_W  = ROW_W + FEAT_W;
  localparam int KSEL_W  = $clog2(MAX_K);
  localparam int KCNT_W  = $clog2(MAX_K + 1);
  localparam int CLS_W   = $clog2(NUM_CLASSES);
  localparam int DATA_W  = 16;
  localparam int DIST_W  = 32;
  localparam int SQ_W    = 44;

  localparam logic [1:0] MODE_CLEAR = 2'd0;
  localparam logic [1:0] MODE_LOAD  = 2'd1;
  localparam logic [1:0] MODE_QUERY = 2'd2;

  localparam logic [1:0] METRIC_EUCLID    = 2'd0;
  localparam logic [1:0] METRIC_MANHATTAN = 2'd1;

  localparam logic [1:0] REG_K        = 2'd0;
  localparam logic [1:0] REG_METRIC   = 2'd1;
  localparam logic [1:0] REG_WEIGHT   = 2'd2;
  localparam logic [1:0] REG_FEATURES = 2'd3;

  localparam logic [31:0] WEIGHT_ONE = 32'h0001_0000;

  typedef struct packed {
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;
    logic [3:0]               label;
  } knn_in_t;

  typedef struct packed {
    logic [3:0] predicted_class;
    logic       no_neighbors;
  } knn_out_t;

  // command from sequencer to the divide / square root unit
  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [SQ_W-1:0]   operand;
    logic [DIST_W-1:0] divisor;
  } knn_iter_cmd_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] result;
  } knn_iter_rsp_t;

endpackage
`default_nettype wire

[hw/rtl/knn_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knn_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module knn_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

[hw/rtl/knn_iter.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// knn_iter
// shared bit-serial unit: restoring divide 65536/d or integer square root
// ----------------------------------------------------------------------------
module knn_iter (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire knn_pkg::knn_iter_cmd_t cmd,
  output knn_pkg::knn_iter_rsp_t      rsp
);

  localparam int SQ_W   = knn_pkg::SQ_W;
  localparam int DIST_W = knn_pkg::DIST_W;
  localparam int STEP_W = 6;
  localparam logic [STEP_W-1:0] DIV_STEPS  = STEP_W'(17);
  localparam logic [STEP_W-1:0] SQRT_STEPS = STEP_W'(SQ_W / 2);

  logic              busy;
  logic              done;
  logic              is_sqrt;
  logic [STEP_W-1:0] steps;
  logic [SQ_W-1:0]   num;
  logic [SQ_W+1:0]   rem;
  logic [DIST_W-1:0] den;
  logic [DIST_W-1:0] quo;

  logic [SQ_W+1:0] rem_shift;
  logic [SQ_W+1:0] trial;
  logic            take;

  always_comb begin
    if (is_sqrt) begin
      rem_shift = {rem[SQ_W-1:0], num[SQ_W-1 -: 2]};
      trial     = {{(SQ_W+2-DIST_W-2){1'b0}}, quo, 2'b01};
    end else begin
      rem_shift = {rem[SQ_W:0], num[SQ_W-1]};
      trial     = {{(SQ_W+2-DIST_W){1'b0}}, den};
    end
    take = rem_shift >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !cmd.start && steps == STEP_W'(1);
      if (cmd.start) begin
        busy    <= 1'b1;
        is_sqrt <= cmd.is_sqrt;
        den     <= cmd.divisor;
        quo     <= '0;
        rem     <= '0;
        if (cmd.is_sqrt) begin
          num   <= cmd.operand;
          steps <= SQRT_STEPS;
        end else begin
          num   <= {17'h10000, 27'd0};
          steps <= DIV_STEPS;
        end
      end else if (busy) begin
        rem   <= take ? rem_shift - trial : rem_shift;
        quo   <= {quo[DIST_W-2:0], take};
        num   <= is_sqrt ? {num[SQ_W-3:0], 2'b00} : {num[SQ_W-2:0], 1'b0};
        steps <= steps - STEP_W'(1);
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign rsp = '{done: done, result: quo};

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy) else $error("iter unit busy after done");

  a_start_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.start |=> busy) else $error("iter unit did not start");

  a_busy_steps: assert property (@(posedge clk) disable iff (rst)
    busy |-> steps != '0) else $error("iter unit busy with no steps left");

endmodule
`default_nettype wire

[hw/rtl/knn_classifier_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// flow: a clear, a load or a non-final query feature passes the accept and step states
// a final query feature clears the 16 vote counters, then per stored row reads its features,
// takes the 22-step square root (euclidean) and, if among the k nearest, inserts the row;
// then each neighbor adds its vote, with reciprocal weights from the 17-step divide
// throughput: one transaction at a time, input stalled until the result is registered
// reset clears row count, position and result valid and sets config to defaults; rams are not cleared
// ----------------------------------------------------------------------------
// knn_classifier_top
// nearest-neighbor classifier around one shared divide / square root unit
// ----------------------------------------------------------------------------
module knn_classifier_top (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              valid_in,
  output logic                   stall_in,
  input  wire knn_pkg::knn_in_t  data_in,
  output logic                   valid_out,
  input  wire logic              stall_out,
  output knn_pkg::knn_out_t      data_out,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [6:0]        cfg_data
);

  localparam int ROW_W  = knn_pkg::ROW_W;
  localparam int CNT_W  = knn_pkg::CNT_W;
  localparam int FEAT_W = knn_pkg::FEAT_W;
  localparam int ADDR_W = knn_pkg::ADDR_W;
  localparam int KSEL_W = knn_pkg::KSEL_W;
  localparam int KCNT_W = knn_pkg::KCNT_W;
  localparam int CLS_W  = knn_pkg::CLS_W;
  localparam int DW     = knn_pkg::DATA_W;
  localparam int DIST_W = knn_pkg::DIST_W;
  localparam int SQ_W   = knn_pkg::SQ_W;
  localparam int MK     = knn_pkg::MAX_K;
  localparam int NC     = knn_pkg::NUM_CLASSES;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_RD     = 4'd1;
  localparam logic [3:0] S_ACC    = 4'd2;
  localparam logic [3:0] S_METRIC = 4'd3;
  localparam logic [3:0] S_SQRT   = 4'd4;
  localparam logic [3:0] S_INS    = 4'd5;
  localparam logic [3:0] S_VRD    = 4'd6;
  localparam logic [3:0] S_VW     = 4'd7;
  localparam logic [3:0] S_VDIV   = 4'd8;
  localparam logic [3:0] S_VADD   = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;
  localparam logic [3:0] S_STEP   = 4'd11;
  localparam logic [3:0] S_VCLR   = 4'd12;

  // configuration
  logic [4:0] k;
  logic [1:0] metric;
  logic       weighting;
  logic [6:0] feature_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      k             <= 5'd5;
      metric        <= 2'd0;
      weighting     <= 1'b0;
      feature_count <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        knn_pkg::REG_K:        k             <= cfg_data[4:0];
        knn_pkg::REG_METRIC:   metric        <= cfg_data[1:0];
        knn_pkg::REG_WEIGHT:   weighting     <= cfg_data[0];
        knn_pkg::REG_FEATURES: feature_count <= cfg_data;
        default: ;
      endcase
    end
  end

  logic [6:0] nf;
  logic [KCNT_W-1:0] kk;
  always_comb begin
    if (feature_count == 7'd0) nf = 7'd1;
    else if (feature_count > 7'(knn_pkg::MAX_FEATURES)) nf = 7'(knn_pkg::MAX_FEATURES);
    else nf = feature_count;
    if (k == 5'd0) kk = KCNT_W'(1);
    else if (k > 5'(MK)) kk = KCNT_W'(MK);
    else kk = KCNT_W'(k);
  end

  logic [3:0]        state;
  logic [CNT_W-1:0]  row_count;
  logic [FEAT_W-1:0] feature_position;
  logic              out_valid;
  knn_pkg::knn_out_t out_data;
  knn_pkg::knn_out_t res_data;

  logic [FEAT_W-1:0] pos;
  logic              last;
  always_comb begin
    pos  = (7'(feature_position) < nf) ? feature_position : FEAT_W'(nf - 7'd1);
    last = (7'(feature_position) + 7'd1) >= nf;
  end

  knn_pkg::knn_in_t item;
  logic [ROW_W-1:0]  row;
  logic [FEAT_W-1:0] fidx;
  logic signed [DW:0] diff;
  logic [DW-1:0]      ad;
  logic [SQ_W-1:0]    sq_acc;
  logic [DIST_W-1:0]  sum_acc;
  logic [DW-1:0]      mx_acc;
  logic [DIST_W-1:0]  row_dist;

  logic [DIST_W-1:0] nd [MK];
  logic [ROW_W-1:0]  nr [MK];
  logic [KCNT_W-1:0] ncount;
  logic [KSEL_W-1:0] vidx;
  logic [DIST_W-1:0] votes [NC];
  logic [DIST_W-1:0] weight;
  logic [CLS_W-1:0]  leader;
  logic              have_leader;
  logic [DIST_W-1:0] best;

  // rams
  logic              tf_we;
  logic [ADDR_W-1:0] tf_addr;
  logic [DW-1:0]     tf_rdata;
  logic              tl_we;
  logic [ROW_W-1:0]  tl_addr;
  logic [CLS_W-1:0]  tl_rdata;
  logic              qf_we;
  logic [FEAT_W-1:0] qf_addr;
  logic [DW-1:0]     qf_rdata;
  logic [CLS_W-1:0]  lbl_sat;

  assign lbl_sat = (32'(item.label) >= NC) ? CLS_W'(NC - 1) : CLS_W'(item.label);

  always_comb begin
    tf_we   = 1'b0;
    tl_we   = 1'b0;
    qf_we   = 1'b0;
    tf_addr = {row, fidx};
    tl_addr = nr[vidx];
    qf_addr = fidx;
    if (state == S_STEP) begin
      tf_addr = {row_count[ROW_W-1:0], pos};
      tl_addr = row_count[ROW_W-1:0];
      qf_addr = pos;
      if (item.mode == knn_pkg::MODE_LOAD && row_count < CNT_W'(knn_pkg::MAX_ROWS)) begin
        tf_we = 1'b1;
        tl_we = last;
      end
      qf_we = item.mode == knn_pkg::MODE_QUERY;
    end
  end

  knn_ram #(.WIDTH(DW), .DEPTH(knn_pkg::MAX_ROWS * knn_pkg::MAX_FEATURES)) u_train_feat (
    .clk(clk), .we(tf_we), .addr(tf_addr), .wdata(item.value), .rdata(tf_rdata)
  );
  knn_ram #(.WIDTH(CLS_W), .DEPTH(knn_pkg::MAX_ROWS)) u_train_lbl (
    .clk(clk), .we(tl_we), .addr(tl_addr), .wdata(lbl_sat), .rdata(tl_rdata)
  );
  knn_ram #(.WIDTH(DW), .DEPTH(knn_pkg::MAX_FEATURES)) u_query_feat (
    .clk(clk), .we(qf_we), .addr(qf_addr), .wdata(item.value), .rdata(qf_rdata)
  );

  knn_pkg::knn_iter_cmd_t icmd;
  knn_pkg::knn_iter_rsp_t irsp;
  knn_iter u_iter (.clk(clk), .rst(rst), .cmd(icmd), .rsp(irsp));

  // start pulse is registered, so it is seen in the wait state
  logic iter_go;
  always_comb begin
    icmd.start   = iter_go;
    icmd.is_sqrt = state == S_SQRT;
    icmd.operand = sq_acc;
    icmd.divisor = nd[vidx];
  end

  assign diff = $signed({qf_rdata[DW-1], qf_rdata}) - $signed({tf_rdata[DW-1], tf_rdata});
  assign ad   = diff[DW] ? DW'(-diff) : diff[DW-1:0];

  // insertion position: first slot whose distance exceeds d (shifted one per cycle)
  logic [KSEL_W-1:0] ins_j;
  logic              ins_ok;
  logic [DIST_W:0]   tot;
  logic [DIST_W-1:0] nv;
  logic [CLS_W-1:0]  vcls;

  assign vcls = tl_rdata;
  assign tot  = {1'b0, votes[vcls]} + {1'b0, weight};
  assign nv   = tot[DIST_W] ? '1 : tot[DIST_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      row_count        <= '0;
      feature_position <= '0;
      out_valid        <= 1'b0;
      ncount           <= '0;
      iter_go          <= 1'b0;
    end else begin
      iter_go <= (state == S_METRIC && metric == knn_pkg::METRIC_EUCLID) ||
                 (state == S_VW && weighting && nd[vidx] != '0);
      if (out_valid && !stall_out && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (valid_in) begin
            item  <= data_in;
            state <= S_STEP;
          end
        end
        S_STEP: begin
          state <= S_IDLE;
          case (item.mode)
            knn_pkg::MODE_CLEAR: begin
              row_count        <= '0;
              feature_position <= '0;
            end
            knn_pkg::MODE_LOAD: begin
              if (row_count < CNT_W'(knn_pkg::MAX_ROWS)) begin
                if (last) begin
                  row_count        <= row_count + CNT_W'(1);
                  feature_position <= '0;
                end else begin
                  feature_position <= pos + FEAT_W'(1);
                end
              end
            end
            knn_pkg::MODE_QUERY: begin
              if (!last) begin
                feature_position <= pos + FEAT_W'(1);
              end else begin
                feature_position <= '0;
                if (row_count == '0) begin
                  res_data <= '{predicted_class: 4'd0, no_neighbors: 1'b1};
                  state    <= S_OUT;
                end else begin
                  row    <= '0;
                  ncount <= '0;
                  vidx   <= '0;
                  state  <= S_VCLR;
                end
              end
            end
            default: ;
          endcase
        end
        S_VCLR: begin
          votes[vidx] <= '0;
          vidx <= vidx + KSEL_W'(1);
          if (32'(vidx) == NC - 1) begin
            fidx  <= '0;
            state <= S_RD;
          end
        end
        S_RD: begin
          sq_acc  <= '0;
          sum_acc <= '0;
          mx_acc  <= '0;
          fidx    <= fidx + FEAT_W'(1);
          state   <= S_ACC;
        end
        S_ACC: begin
          sq_acc  <= sq_acc + SQ_W'(ad * ad);
          sum_acc <= sum_acc + DIST_W'(ad);
          if (ad > mx_acc) mx_acc <= ad;
          if (7'(fidx) >= nf || fidx == '0) begin
            state <= S_METRIC;
          end
          fidx <= fidx + FEAT_W'(1);
        end
        S_METRIC: begin
          if (metric == knn_pkg::METRIC_EUCLID) begin
            state <= S_SQRT;
          end else begin
            row_dist <= (metric == knn_pkg::METRIC_MANHATTAN) ? sum_acc : DIST_W'(mx_acc);
            state    <= S_INS;
            ins_j    <= ncount < kk ? KSEL_W'(ncount) : KSEL_W'(kk - KCNT_W'(1));
            ins_ok   <= 1'b0;
          end
        end
        S_SQRT: begin
          if (irsp.done) begin
            row_dist <= irsp.result;
            state    <= S_INS;
            ins_j    <= ncount < kk ? KSEL_W'(ncount) : KSEL_W'(kk - KCNT_W'(1));
            ins_ok   <= 1'b0;
          end
        end
        S_INS: begin
          // first cycle decides whether the row enters, then bubbles down one slot a cycle
          if (!ins_ok) begin
            if (ncount < kk) begin
              ncount <= ncount + KCNT_W'(1);
              ins_ok <= 1'b1;
            end else if (nd[ins_j] > row_dist) begin
              ins_ok <= 1'b1;
            end else if (32'(row) + 1 >= 32'(row_count)) begin
              vidx        <= KSEL_W'(ncount - KCNT_W'(1));
              have_leader <= 1'b0;
              state       <= S_VRD;
            end else begin
              row   <= row + ROW_W'(1);
              fidx  <= '0;
              state <= S_RD;
            end
          end else if (ins_j != '0 && nd[ins_j - KSEL_W'(1)] > row_dist) begin
            nd[ins_j] <= nd[ins_j - KSEL_W'(1)];
            nr[ins_j] <= nr[ins_j - KSEL_W'(1)];
            ins_j <= ins_j - KSEL_W'(1);
          end else begin
            nd[ins_j] <= row_dist;
            nr[ins_j] <= row;
            ins_ok    <= 1'b0;
            if (32'(row) + 1 >= 32'(row_count)) begin
              vidx        <= KSEL_W'(ncount - KCNT_W'(1));
              have_leader <= 1'b0;
              state       <= S_VRD;
            end else begin
              row   <= row + ROW_W'(1);
              fidx  <= '0;
              state <= S_RD;
            end
          end
        end
        S_VRD: begin
          state <= S_VW;
        end
        S_VW: begin
          if (!weighting) begin
            weight <= knn_pkg::WEIGHT_ONE;
            state  <= S_VADD;
          end else if (nd[vidx] == '0) begin
            weight <= '1;
            state  <= S_VADD;
          end else begin
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          if (irsp.done) begin
            weight <= irsp.result;
            state  <= S_VADD;
          end
        end
        S_VADD: begin
          votes[vcls] <= nv;
          if (have_leader && leader == vcls) begin
            best <= nv;
          end else if (!have_leader || nv >= best) begin
            leader      <= vcls;
            best        <= nv;
            have_leader <= 1'b1;
          end
          if (vidx == '0) begin
            state <= S_OUT;
            res_data.no_neighbors <= 1'b0;
            res_data.predicted_class <= 4'((have_leader && leader == vcls) || !have_leader
                                           || nv >= best ? vcls : leader);
          end else begin
            vidx  <= vidx - KSEL_W'(1);
            state <= S_VRD;
          end
        end
        S_OUT: begin
          if (!out_valid || !stall_out) begin
            out_valid <= 1'b1;
            out_data  <= res_data;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign stall_in  = state != S_IDLE;
  assign valid_out = out_valid;
  assign data_out  = out_data;

  property p_out_hold;
    @(posedge clk) disable iff (rst) valid_out && stall_out |=> valid_out && $stable(data_out);
  endproperty
  a_out_hold: assert property (p_out_hold) else $error("result dropped under stall");

  a_ncount_le_k: assert property (@(posedge clk) disable iff (rst)
    ncount <= KCNT_W'(MK)) else $error("neighbor count above max k");

  a_rows_cap: assert property (@(posedge clk) disable iff (rst)
    row_count <= CNT_W'(knn_pkg::MAX_ROWS)) else $error("row count past capacity");

endmodule
`default_nettype wire

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for knn_classifier_top: a queue-fed driver sends config writes and
// clear, training, query and invalid-mode transactions with random gaps, a monitor with random
// stalls checks every class result against a behavioral predictor
// ----------------------------------------------------------------------------
module tb;

  localparam int LIMIT_CYCLES = 3000000;

  typedef struct {
    bit                 is_cfg;
    logic [1:0]         cfg_idx;
    logic [6:0]         cfg_val;
    knn_pkg::knn_in_t   item;
  } pending_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     valid_in = 1'b0;
  logic     stall_in;
  knn_pkg::knn_in_t  data_in = '0;
  logic     valid_out;
  logic     stall_out = 1'b0;
  knn_pkg::knn_out_t data_out;
  logic     cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [6:0] cfg_data = '0;

  knn_classifier_top i_dut (
    .clk(clk), .rst(rst),
    .valid_in(valid_in), .stall_in(stall_in), .data_in(data_in),
    .valid_out(valid_out), .stall_out(stall_out), .data_out(data_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------- predictor state ----------------
  logic signed [15:0] train_feat [0:knn_pkg::MAX_ROWS-1][0:knn_pkg::MAX_FEATURES-1];
  logic [3:0]         train_label [0:knn_pkg::MAX_ROWS-1];
  logic signed [15:0] query_feat [0:knn_pkg::MAX_FEATURES-1];
  int unsigned        rows_stored = 0;
  int unsigned        feat_pos = 0;
  logic [4:0]         cfg_k = 5'd5;
  logic [1:0]         cfg_metric = knn_pkg::METRIC_EUCLID;
  logic               cfg_weight = 1'b0;
  logic [6:0]         cfg_feat = 7'd64;

  knn_pkg::knn_out_t class_expected [$];
  pending_t   pending [$];
  int         errors = 0;
  int         results_seen = 0;
  int         queries_sent = 0;
  int         capacity_hits = 0;

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int unsigned row_length(logic [6:0] fc);
    if (fc == 0) return 1;
    if (fc > knn_pkg::MAX_FEATURES) return knn_pkg::MAX_FEATURES;
    return fc;
  endfunction

  function automatic logic [31:0] floor_sqrt(logic [63:0] v);
    logic [63:0] res;
    logic [63:0] trial;
    res = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = res | (64'd1 << b);
      if (trial * trial <= v) res = trial;
    end
    return res[31:0];
  endfunction

  function automatic logic [31:0] row_gap(int unsigned r, int unsigned nf);
    logic [63:0] sq;
    logic [31:0] sum, mx, ad;
    int d;
    sq = 0; sum = 0; mx = 0;
    for (int unsigned f = 0; f < nf; f++) begin
      d = int'(query_feat[f]) - int'(train_feat[r][f]);
      ad = (d < 0) ? -d : d;
      sq += {32'd0, ad} * {32'd0, ad};
      sum += ad;
      if (ad > mx) mx = ad;
    end
    if (cfg_metric == knn_pkg::METRIC_EUCLID) return floor_sqrt(sq);
    if (cfg_metric == knn_pkg::METRIC_MANHATTAN) return sum;
    return mx;
  endfunction

  function automatic logic [3:0] vote_winner(int unsigned nf);
    logic [31:0] near_d [0:knn_pkg::MAX_K-1];
    int unsigned near_r [0:knn_pkg::MAX_K-1];
    logic [31:0] votes [0:knn_pkg::NUM_CLASSES-1];
    int unsigned cnt, kk, j;
    logic [31:0] d, w;
    logic [32:0] t;
    logic [31:0] nv, best;
    logic [3:0]  c, leader;
    bit          have;
    cnt = 0;
    kk = (cfg_k == 0) ? 1 : (cfg_k > knn_pkg::MAX_K ? knn_pkg::MAX_K : cfg_k);
    for (int unsigned r = 0; r < rows_stored; r++) begin
      d = row_gap(r, nf);
      if (cnt < kk) begin
        j = cnt; cnt++;
      end else if (near_d[cnt-1] > d) begin
        j = cnt - 1;
      end else begin
        continue;
      end
      while (j > 0 && near_d[j-1] > d) begin
        near_d[j] = near_d[j-1]; near_r[j] = near_r[j-1]; j--;
      end
      near_d[j] = d; near_r[j] = r;
    end
    for (int i = 0; i < knn_pkg::NUM_CLASSES; i++) votes[i] = 0;
    have = 0; leader = 0; best = 0;
    // farthest first, so nearer neighbors win ties
    for (int i = int'(cnt) - 1; i >= 0; i--) begin
      c = train_label[near_r[i]];
      if (!cfg_weight) w = knn_pkg::WEIGHT_ONE;
      else if (near_d[i] == 0) w = 32'hFFFF_FFFF;
      else w = knn_pkg::WEIGHT_ONE / near_d[i];
      t = {1'b0, votes[c]} + {1'b0, w};
      nv = t[32] ? 32'hFFFF_FFFF : t[31:0];
      if (have && leader == c) begin
        best = nv;
      end else if (!have || nv >= best) begin
        leader = c; best = nv; have = 1;
      end
      votes[c] = nv;
    end
    return leader;
  endfunction

  task automatic predict_item(knn_pkg::knn_in_t it);
    int unsigned nf, pos;
    bit last;
    knn_pkg::knn_out_t res;
    nf = row_length(cfg_feat);
    pos = (feat_pos < nf) ? feat_pos : nf - 1;
    last = (feat_pos + 1 >= nf);
    case (it.mode)
      knn_pkg::MODE_CLEAR: begin
        rows_stored = 0; feat_pos = 0;
      end
      knn_pkg::MODE_LOAD: begin
        if (rows_stored >= knn_pkg::MAX_ROWS) begin
          capacity_hits++;
        end else begin
          train_feat[rows_stored][pos] = it.value;
          if (last) begin
            train_label[rows_stored] = it.label;
            rows_stored++; feat_pos = 0;
          end else begin
            feat_pos = pos + 1;
          end
        end
      end
      knn_pkg::MODE_QUERY: begin
        query_feat[pos] = it.value;
        if (!last) begin
          feat_pos = pos + 1;
        end else begin
          feat_pos = 0;
          if (rows_stored == 0) begin
            res.predicted_class = 0; res.no_neighbors = 1'b1;
          end else begin
            res.predicted_class = vote_winner(nf); res.no_neighbors = 1'b0;
          end
          class_expected.push_back(res);
        end
      end
      default: ;
    endcase
  endtask

  // ---------------- driver ----------------
  int  gap_left = 0;
  int  quiet_since = 0;
  bit  no_idle = 0;

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(60, 10);
  endfunction

  always @(posedge clk) begin
    bit nv;
    pending_t p;
    if (rst) begin
      valid_in <= 1'b0;
      cfg_we <= 1'b0;
    end else begin
      nv = valid_in;
      cfg_we <= 1'b0;
      if (valid_in && !stall_in) begin
        predict_item(data_in);
        nv = 1'b0;
        quiet_since = 0;
      end else begin
        quiet_since++;
      end
      if ($urandom_range(199) == 0) no_idle = !no_idle;
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          p = pending[0];
          if (p.is_cfg) begin
            // idle: nothing owed and the last transaction has drained
            if (class_expected.size() == 0 && quiet_since >= 8) begin
              cfg_we <= 1'b1;
              cfg_index <= p.cfg_idx;
              cfg_data <= p.cfg_val;
              case (p.cfg_idx)
                knn_pkg::REG_K:        cfg_k = p.cfg_val[4:0];
                knn_pkg::REG_METRIC:   cfg_metric = p.cfg_val[1:0];
                knn_pkg::REG_WEIGHT:   cfg_weight = p.cfg_val[0];
                knn_pkg::REG_FEATURES: cfg_feat = p.cfg_val;
                default: ;
              endcase
              void'(pending.pop_front());
            end
          end else begin
            data_in <= p.item;
            nv = 1'b1;
            if (p.item.mode == knn_pkg::MODE_QUERY) queries_sent++;
            void'(pending.pop_front());
            gap_left = pick_gap();
          end
        end
      end
      valid_in <= nv;
    end
  end

  // ---------------- monitor ----------------
  int  hold_left = 0;
  bit  held_once = 0;

  always @(posedge clk) begin
    knn_pkg::knn_out_t want;
    if (!rst) begin
      if (valid_out && !stall_out) begin
        results_seen++;
        if (class_expected.size() == 0) begin
          report_mismatch("unexpected result transaction", results_seen, results_seen - 1);
        end else begin
          want = class_expected.pop_front();
          if (data_out.predicted_class !== want.predicted_class)
            report_mismatch("predicted_class", data_out.predicted_class,
                            want.predicted_class);
          if (data_out.no_neighbors !== want.no_neighbors)
            report_mismatch("no_neighbors", data_out.no_neighbors, want.no_neighbors);
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_out <= 1'b1;
      end else if (!held_once && results_seen == 20) begin
        held_once = 1;
        hold_left = 4000;
        stall_out <= 1'b1;
      end else if (!no_idle && $urandom_range(99) == 0) begin
        hold_left = $urandom_range(40, 10);
        stall_out <= 1'b1;
      end else begin
        stall_out <= !no_idle && ($urandom_range(99) < 20);
      end
    end
  end

  // ---------------- stimulus ----------------
  int unsigned gen_nf;
  int          items_queued = 0;

  task automatic push_cfg(logic [1:0] idx, logic [6:0] val);
    pending_t p;
    p.is_cfg = 1; p.cfg_idx = idx; p.cfg_val = val; p.item = '0;
    pending.push_back(p);
    if (idx == knn_pkg::REG_FEATURES) gen_nf = row_length(val);
  endtask

  task automatic push_item(logic [1:0] mode, logic [15:0] value, logic [3:0] label);
    pending_t p;
    p.is_cfg = 0; p.cfg_idx = '0; p.cfg_val = '0;
    p.item.mode = mode; p.item.value = value; p.item.label = label;
    pending.push_back(p);
    items_queued++;
  endtask

  function automatic logic [15:0] rand_value(bit narrow);
    if (narrow) return 16'($urandom_range(6)) - 16'd3;
    return 16'($urandom);
  endfunction

  task automatic push_row(logic [1:0] mode, bit narrow);
    logic [3:0] lab;
    lab = 4'($urandom);
    for (int unsigned f = 0; f < gen_nf; f++) push_item(mode, rand_value(narrow), lab);
  endtask

  initial begin
    int nrows;
    bit narrow;
    gen_nf = 64;
    // directed: empty set, extremes, zero distance, odd register values
    push_cfg(knn_pkg::REG_FEATURES, 7'd2);
    push_item(knn_pkg::MODE_QUERY, 16'h0000, 4'd0);
    push_item(knn_pkg::MODE_QUERY, 16'h7FFF, 4'd0);
    push_item(2'd3, 16'h1234, 4'd9);
    push_item(knn_pkg::MODE_LOAD, 16'h7FFF, 4'd0);
    push_item(knn_pkg::MODE_LOAD, 16'h8000, 4'd15);
    push_item(knn_pkg::MODE_LOAD, 16'h8000, 4'd0);
    push_item(knn_pkg::MODE_LOAD, 16'h7FFF, 4'd0);
    push_item(knn_pkg::MODE_LOAD, 16'h0000, 4'd0);
    push_item(knn_pkg::MODE_LOAD, 16'h0000, 4'd3);
    push_item(knn_pkg::MODE_QUERY, 16'h0000, 4'd0);
    push_item(knn_pkg::MODE_QUERY, 16'h0000, 4'd0);
    push_cfg(knn_pkg::REG_WEIGHT, 7'd1);
    push_item(knn_pkg::MODE_QUERY, 16'h0000, 4'd0);
    push_item(knn_pkg::MODE_QUERY, 16'h0000, 4'd0);
    push_cfg(knn_pkg::REG_METRIC, 7'd3);
    push_cfg(knn_pkg::REG_K, 7'd0);
    push_item(knn_pkg::MODE_QUERY, 16'h7FFF, 4'd0);
    push_item(knn_pkg::MODE_QUERY, 16'h8000, 4'd0);
    // row length lowered in the middle of a training row
    push_item(knn_pkg::MODE_CLEAR, 16'h0000, 4'd0);
    push_cfg(knn_pkg::REG_FEATURES, 7'd3);
    push_item(knn_pkg::MODE_LOAD, 16'h0005, 4'd0);
    push_item(knn_pkg::MODE_LOAD, 16'hFFF0, 4'd0);
    push_cfg(knn_pkg::REG_FEATURES, 7'd2);
    push_item(knn_pkg::MODE_LOAD, 16'h0009, 4'd7);
    push_item(knn_pkg::MODE_QUERY, 16'h0004, 4'd0);
    push_item(knn_pkg::MODE_QUERY, 16'h0008, 4'd0);
    // training and query share the position
    push_item(knn_pkg::MODE_LOAD, 16'h0001, 4'd2);
    push_item(knn_pkg::MODE_QUERY, 16'h0002, 4'd0);

    // full neighbor set: one feature per row, more rows than k
    push_item(knn_pkg::MODE_CLEAR, 16'h0000, 4'd0);
    push_cfg(knn_pkg::REG_FEATURES, 7'd0);
    push_cfg(knn_pkg::REG_K, 7'd16);
    push_cfg(knn_pkg::REG_METRIC, 7'd1);
    for (int r = 0; r < 40; r++) push_row(knn_pkg::MODE_LOAD, r % 3 == 0);
    push_row(knn_pkg::MODE_QUERY, 1);
    push_row(knn_pkg::MODE_QUERY, 0);

    while (items_queued < 580) begin
      case ($urandom_range(4))
        0: push_cfg(knn_pkg::REG_K, 7'd1);
        1: push_cfg(knn_pkg::REG_K, 7'd16);
        2: push_cfg(knn_pkg::REG_K, 7'd31);
        default: push_cfg(knn_pkg::REG_K, 7'($urandom_range(15, 2)));
      endcase
      push_cfg(knn_pkg::REG_METRIC, 7'($urandom_range(3)));
      push_cfg(knn_pkg::REG_WEIGHT, 7'($urandom_range(1)));
      if ($urandom_range(9) == 0 && items_queued < 250) begin
        push_cfg(knn_pkg::REG_FEATURES, $urandom_range(1) ? 7'd64 : 7'd127);
        nrows = $urandom_range(2, 1);
      end else begin
        push_cfg(knn_pkg::REG_FEATURES, 7'($urandom_range(6, 1)));
        nrows = $urandom_range(25, 1);
      end
      push_item(knn_pkg::MODE_CLEAR, 16'($urandom), 4'($urandom));
      narrow = $urandom_range(1);
      for (int r = 0; r < nrows; r++) begin
        push_row(knn_pkg::MODE_LOAD, narrow);
        if ($urandom_range(5) == 0) push_row(knn_pkg::MODE_QUERY, narrow);
        if ($urandom_range(19) == 0) push_item(2'd3, 16'($urandom), 4'($urandom));
        if ($urandom_range(29) == 0 && gen_nf > 1) begin
          // broken row thrown away by a clear
          push_item(knn_pkg::MODE_LOAD, rand_value(narrow), 4'($urandom));
          push_item(knn_pkg::MODE_CLEAR, 16'h0000, 4'd0);
        end
      end
      for (int q = $urandom_range(3, 1); q > 0; q--) push_row(knn_pkg::MODE_QUERY, narrow);
    end

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    wait (pending.size() == 0 && !valid_in);
    wait (class_expected.size() == 0);
    repeat (100) @(posedge clk);
    $display("run covered %0d queued transactions, %0d queries, %0d results",
             items_queued, queries_sent, results_seen);
    $display("loads beyond capacity: %0d, mismatches: %0d", capacity_hits, errors);
    if (errors == 0 && class_expected.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  int cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

endmodule
